// ----- hw/rtl/gcpe_pkg.sv -----
// Shared types, opcodes, microcode table and cursor bitmap for the glyph and
// cursor pixel expander. No dependencies.
`default_nettype none

package gcpe_pkg;

    localparam int GLYPH_COUNT_DEF = 95;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;

    localparam logic [7:0]  FIRST_CODE    = 8'd32;
    localparam logic [7:0]  LAST_CODE     = 8'd126;
    localparam logic [7:0]  GLYPH_MSB     = 8'h80;
    localparam logic [31:0] CURSOR_BORDER = 32'h00FF_FFFF;
    localparam logic [31:0] CURSOR_FILL   = 32'h0000_0000;
    localparam logic [10:0] RESET_WIDTH   = 11'd800;
    localparam logic [10:0] RESET_HEIGHT  = 11'd600;

    // last row/column index of a glyph cell and of the cursor cell
    localparam logic [3:0]  GLYPH_LAST    = 4'd7;
    localparam logic [3:0]  CURSOR_LAST   = 4'd9;

    localparam logic        CFG_WIDTH     = 1'b0;
    localparam logic        CFG_HEIGHT    = 1'b1;

    localparam logic [1:0]  OP_LOAD        = 2'd0;
    localparam logic [1:0]  OP_OPAQUE      = 2'd1;
    localparam logic [1:0]  OP_TRANSPARENT = 2'd2;
    localparam logic [1:0]  OP_CURSOR      = 2'd3;

    localparam logic [1:0]  KIND_CLEAR  = 2'd0;
    localparam logic [1:0]  KIND_BORDER = 2'd1;
    localparam logic [1:0]  KIND_FILL   = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         char_code;
        logic [2:0]         glyph_row;
        logic [7:0]         glyph_bits;
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic [31:0]        fore_color;
        logic [31:0]        back_color;
    } t_request;

    typedef struct packed {
        logic [19:0] pixel_index;
        logic [31:0] pixel_color;
        logic        last_pixel;
    } t_result;

    // microcode addresses
    typedef enum logic [2:0] {
        UP_IDLE,
        UP_LOAD,
        UP_FETCH,
        UP_DRAW,
        UP_FLUSH
    } t_upc;

    typedef enum logic [2:0] {
        ACT_IDLE,
        ACT_WRITE,
        ACT_FETCH,
        ACT_PIXEL,
        ACT_FLUSH
    } t_act;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_PIX_MORE
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  tgt_t;
        t_upc  tgt_f;
    } t_uword;

    // control store
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            UP_IDLE:  w = '{ACT_IDLE,  COND_DISPATCH, UP_IDLE,  UP_IDLE};
            UP_LOAD:  w = '{ACT_WRITE, COND_ALWAYS,   UP_IDLE,  UP_IDLE};
            UP_FETCH: w = '{ACT_FETCH, COND_ALWAYS,   UP_DRAW,  UP_DRAW};
            UP_DRAW:  w = '{ACT_PIXEL, COND_PIX_MORE, UP_DRAW,  UP_FLUSH};
            UP_FLUSH: w = '{ACT_FLUSH, COND_ALWAYS,   UP_IDLE,  UP_IDLE};
            default:  w = '{ACT_IDLE,  COND_ALWAYS,   UP_IDLE,  UP_IDLE};
        endcase
        return w;
    endfunction

    // cursor rows, two bits per column, column 0 in the low bits
    function automatic logic [19:0] cursor_row(input logic [3:0] row);
        logic [19:0] r;
        case (row)
            4'd0:    r = 20'b00_00_00_00_00_00_00_00_01_01;
            4'd1:    r = 20'b00_00_00_00_00_00_00_01_10_01;
            4'd2:    r = 20'b00_00_00_00_00_00_01_10_10_01;
            4'd3:    r = 20'b00_00_00_00_00_01_10_10_10_01;
            4'd4:    r = 20'b00_00_00_00_01_10_10_10_10_01;
            4'd5:    r = 20'b00_00_00_01_10_10_10_10_10_01;
            4'd6:    r = 20'b00_00_01_10_10_10_10_10_10_01;
            4'd7:    r = 20'b00_01_01_01_01_01_01_10_10_01;
            4'd8:    r = 20'b00_00_00_00_00_00_00_01_01_01;
            4'd9:    r = 20'b00_00_00_00_00_00_00_00_00_01;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/glyph_and_cursor_pixel_expander.sv -----
// Glyph and cursor pixel expander top level: microcoded sequencer, font
// store and clipping datapath. Depends on gcpe_pkg.
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+---------------------------
//  request   | start, busy, i_req                  | taken when start & !busy
//  result    | o_strobe, o_result                  | one cycle, cannot stall
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data     | write when i_cfg_we high
//
// Busy after the accepting edge: a load for its write step, a rejected code not
// at all. Character: fetch, 64 cell positions, flush. Cursor: 100 cell
// positions, flush. One cell position per cycle through the shared clip/index
// datapath; the font store read is registered and runs one column ahead.
// Results trail by one pixel so the last one can be flagged. Reset is
// synchronous and clears control state; the font store is not cleared.
`default_nettype none

module glyph_and_cursor_pixel_expander
    import gcpe_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_request    i_req,
    output logic             o_strobe,
    output t_result          o_result,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [10:0] i_cfg_data
);

    localparam int          FONT_DEPTH = GLYPH_COUNT * 8;
    localparam int          AW         = $clog2(FONT_DEPTH);
    localparam logic [12:0] MaxW       = 13'(MAX_WIDTH);
    localparam logic [12:0] MaxH       = 13'(MAX_HEIGHT);

    t_upc        r_upc, n_upc;
    t_uword      uw;
    t_request    r_req;
    logic [10:0] r_width, r_height;
    logic [3:0]  r_row, r_col;
    logic [7:0]  r_font [FONT_DEPTH];
    logic [7:0]  r_rd;
    logic        r_pend_v;
    logic [19:0] r_pend_idx;
    logic [31:0] r_pend_color;
    logic        r_strobe;
    t_result     r_out;

    // control decode
    logic        accept, do_write, do_pixel, do_flush;

    // datapath
    logic [7:0]  code_off;
    logic        code_ok;
    logic [3:0]  lim;
    logic        pix_more;
    logic [12:0] w13, h13;
    logic [10:0] w_eff, h_eff;
    logic [12:0] px, py;
    logic        vis;
    logic [22:0] prod;
    logic [19:0] idx;
    logic [19:0] cur_row;
    logic [1:0]  kind;
    logic        bit_set;
    logic        present;
    logic [31:0] color;
    logic        hit;
    logic [2:0]  rd_row;
    logic [10:0] rd_full, wr_full;

    function automatic logic [6:0] code_off_r(input logic [7:0] code);
        logic [7:0] d;
        d = code - FIRST_CODE;
        return d[6:0];
    endfunction

    assign uw = ucode(r_upc);

    // code range and glyph number
    assign code_off = i_req.char_code - FIRST_CODE;
    assign code_ok  = (i_req.char_code >= FIRST_CODE) && (i_req.char_code <= LAST_CODE)
                      && ({1'b0, code_off} < 9'(GLYPH_COUNT));

    assign lim      = (r_req.opcode == OP_CURSOR) ? CURSOR_LAST : GLYPH_LAST;
    assign pix_more = !((r_row == lim) && (r_col == lim));

    // next microcode address
    always_comb begin
        n_upc = UP_IDLE;
        case (uw.cond)
            COND_ALWAYS:   n_upc = uw.tgt_t;
            COND_PIX_MORE: n_upc = pix_more ? uw.tgt_t : uw.tgt_f;
            COND_DISPATCH: begin
                if (!start) begin
                    n_upc = UP_IDLE;
                end else if (i_req.opcode == OP_CURSOR) begin
                    n_upc = UP_DRAW;
                end else if (!code_ok) begin
                    n_upc = UP_IDLE;
                end else if (i_req.opcode == OP_LOAD) begin
                    n_upc = UP_LOAD;
                end else begin
                    n_upc = UP_FETCH;
                end
            end
            default:       n_upc = UP_IDLE;
        endcase
    end

    // control outputs of the current micro-step
    always_comb begin
        busy     = 1'b1;
        accept   = 1'b0;
        do_write = 1'b0;
        do_pixel = 1'b0;
        do_flush = 1'b0;
        case (uw.act)
            ACT_IDLE: begin
                busy   = 1'b0;
                accept = start;
            end
            ACT_WRITE: do_write = 1'b1;
            ACT_FETCH: ;
            ACT_PIXEL: do_pixel = 1'b1;
            ACT_FLUSH: do_flush = 1'b1;
            default:   ;
        endcase
    end

    // effective screen size
    assign w13   = ({2'b0, r_width}  > MaxW) ? MaxW : {2'b0, r_width};
    assign h13   = ({2'b0, r_height} > MaxH) ? MaxH : {2'b0, r_height};
    assign w_eff = w13[10:0];
    assign h_eff = h13[10:0];

    // pixel position and clipping
    assign px  = {r_req.origin_x[11], r_req.origin_x} + {9'b0, r_col};
    assign py  = {r_req.origin_y[11], r_req.origin_y} + {9'b0, r_row};
    assign vis = !px[12] && !py[12]
                 && (px[11:0] < {1'b0, w_eff}) && (py[11:0] < {1'b0, h_eff});
    assign prod = 23'(py[11:0]) * 23'(w_eff);
    assign idx  = prod[19:0] + {8'b0, px[11:0]};

    // pixel kind and color
    assign cur_row = cursor_row(r_row);
    assign kind    = cur_row[{r_col, 1'b0} +: 2];
    assign bit_set = |(r_rd & (GLYPH_MSB >> r_col[2:0]));

    always_comb begin
        if (r_req.opcode == OP_CURSOR) begin
            present = (kind != KIND_CLEAR);
            color   = (kind == KIND_BORDER) ? CURSOR_BORDER : CURSOR_FILL;
        end else begin
            present = bit_set || (r_req.opcode == OP_OPAQUE);
            color   = bit_set ? r_req.fore_color : r_req.back_color;
        end
    end

    assign hit = do_pixel && present && vis;

    // font read runs one column ahead so the row is ready at column 0
    assign rd_row  = (r_col[2:0] == GLYPH_LAST[2:0]) ? r_row[2:0] + 3'd1 : r_row[2:0];
    assign rd_full = {1'b0, code_off_r(r_req.char_code), rd_row};
    assign wr_full = {1'b0, code_off_r(r_req.char_code), r_req.glyph_row};

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_font[wr_full[AW-1:0]] <= r_req.glyph_bits;
        end
        r_rd <= r_font[rd_full[AW-1:0]];
    end

    // sequencer, counters, config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc    <= UP_IDLE;
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            r_upc <= n_upc;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else begin
                    r_height <= i_cfg_data;
                end
            end
            if (accept) begin
                r_row <= '0;
                r_col <= '0;
            end else if (do_pixel) begin
                if (r_col == lim) begin
                    r_col <= '0;
                    r_row <= r_row + 4'd1;
                end else begin
                    r_col <= r_col + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    // one-pixel holding stage so the final pixel can carry the last flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (hit || do_flush) && r_pend_v;
            if (hit) begin
                r_pend_v <= 1'b1;
            end else if (do_flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_pend_idx   <= idx;
            r_pend_color <= color;
        end
        if ((hit || do_flush) && r_pend_v) begin
            r_out.pixel_index <= r_pend_idx;
            r_out.pixel_color <= r_pend_color;
            r_out.last_pixel  <= do_flush;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // no pixel may be held across a request boundary
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UP_IDLE) |-> !r_pend_v)
        else $error("pending pixel held while idle");

    // a flagged last pixel closes the burst
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_pixel) |=> !o_strobe)
        else $error("result right after last pixel");

    // results only come from work in progress
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a running request");

    // cell counters stay inside the cell
    a_cell_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UP_DRAW) |-> ((r_col <= lim) && (r_row <= lim)))
        else $error("cell counter out of range");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for glyph_and_cursor_pixel_expander: queued glyph loads, character
// and cursor draws under several screen sizes, pixel writes checked in order.
// Depends on gcpe_pkg and the expander RTL.

module tb_top;
    import gcpe_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE      = 120;   // longer than a full cursor walk
    localparam int PHASE_ITEMS = 65;
    localparam int PHASES      = 7;
    localparam logic [63:0] SPACE_ART = 64'hFF81_005A_A53C_00FF;

    typedef struct {
        t_request    rq;
        int unsigned gap;
        bit          drain;     // hold off until all pixels are back
    } t_pending;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    logic        busy;
    t_request    req_drv  = '0;
    logic        o_strobe;
    t_result     o_result;
    logic        cfg_we   = 1'b0;
    logic        cfg_idx  = CFG_WIDTH;
    logic [10:0] cfg_data = '0;

    // predictor state
    logic [7:0]  font_rows [GLYPH_COUNT_DEF*8];
    logic [10:0] width_reg  = RESET_WIDTH;
    logic [10:0] height_reg = RESET_HEIGHT;
    t_result     expected_pixels [$];

    // stimulus state
    t_pending    request_q [$];
    logic [7:0]  rows_loaded [GLYPH_COUNT_DEF];
    int          ready_codes [$];
    int          burst_left = 0;
    int          gap_count  = 0;

    int unsigned n_requests = 0;
    int unsigned n_pixels   = 0;
    int unsigned n_errors   = 0;
    int unsigned n_cycles   = 0;

    glyph_and_cursor_pixel_expander dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (req_drv),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // arrow sprite, column 0 leftmost
    function automatic logic [0:9] arrow_edge(input int r);
        case (r)
            0:       return 10'b1100000000;
            1:       return 10'b1010000000;
            2:       return 10'b1001000000;
            3:       return 10'b1000100000;
            4:       return 10'b1000010000;
            5:       return 10'b1000001000;
            6:       return 10'b1000000100;
            7:       return 10'b1001111110;
            8:       return 10'b1110000000;
            default: return 10'b1000000000;
        endcase
    endfunction

    function automatic logic [0:9] arrow_fill(input int r);
        case (r)
            1:       return 10'b0100000000;
            2:       return 10'b0110000000;
            3:       return 10'b0111000000;
            4:       return 10'b0111100000;
            5:       return 10'b0111110000;
            6:       return 10'b0111111000;
            7:       return 10'b0110000000;
            default: return 10'b0000000000;
        endcase
    endfunction

    function automatic int eff_dim(input logic [10:0] v, input int cap);
        return (int'(v) > cap) ? cap : int'(v);
    endfunction

    // Updates the font on loads and appends the pixel writes a request produces.
    function automatic void expand_request(input t_request rq);
        t_result     batch [$];
        t_result     px;
        int          w, h, ox, oy, x, y, g, size;
        bit          draw;
        logic [31:0] color;
        logic [0:9]  edge_row, fill_row;
        logic [7:0]  line;
        w  = eff_dim(width_reg, MAX_WIDTH_DEF);
        h  = eff_dim(height_reg, MAX_HEIGHT_DEF);
        ox = $signed(rq.origin_x);
        oy = $signed(rq.origin_y);
        g  = int'(rq.char_code) - int'(FIRST_CODE);
        if (rq.opcode != OP_CURSOR) begin
            if (rq.char_code < FIRST_CODE || rq.char_code > LAST_CODE || g >= GLYPH_COUNT_DEF)
                return;
            if (rq.opcode == OP_LOAD) begin
                font_rows[g*8 + int'(rq.glyph_row)] = rq.glyph_bits;
                return;
            end
        end
        size = (rq.opcode == OP_CURSOR) ? 10 : 8;
        for (int r = 0; r < size; r++) begin
            if (rq.opcode == OP_CURSOR) begin
                edge_row = arrow_edge(r);
                fill_row = arrow_fill(r);
            end else begin
                line = font_rows[g*8 + r];
            end
            for (int c = 0; c < size; c++) begin
                if (rq.opcode == OP_CURSOR) begin
                    draw  = edge_row[c] || fill_row[c];
                    color = edge_row[c] ? CURSOR_BORDER : CURSOR_FILL;
                end else begin
                    draw  = line[7-c] || rq.opcode == OP_OPAQUE;
                    color = line[7-c] ? rq.fore_color : rq.back_color;
                end
                x = ox + c;
                y = oy + r;
                if (draw && x >= 0 && y >= 0 && x < w && y < h) begin
                    px.pixel_index = 20'(y * w + x);
                    px.pixel_color = color;
                    px.last_pixel  = 1'b0;
                    batch.push_back(px);
                end
            end
        end
        if (batch.size() > 0) begin
            px = batch.pop_back();
            px.last_pixel = 1'b1;
            batch.push_back(px);
        end
        foreach (batch[i]) expected_pixels.push_back(batch[i]);
    endfunction

    // request driver
    always @(posedge i_clk) begin : drive_requests
        t_pending nxt;
        if (!i_rst_n) begin
            start     <= 1'b0;
            gap_count <= 0;
        end else if (start) begin
            if (!busy) begin
                expand_request(req_drv);
                n_requests++;
                if (request_q.size() != 0 && request_q[0].gap == 0 && !request_q[0].drain) begin
                    nxt = request_q.pop_front();
                    req_drv <= nxt.rq;
                end else begin
                    start <= 1'b0;
                end
            end
        end else if (request_q.size() != 0) begin
            if (gap_count < request_q[0].gap) begin
                gap_count <= gap_count + 1;
            end else if (!request_q[0].drain || expected_pixels.size() == 0) begin
                nxt = request_q.pop_front();
                req_drv   <= nxt.rq;
                start     <= 1'b1;
                gap_count <= 0;
            end
        end
    end

    // pixel checker
    always @(posedge i_clk) begin : check_pixels
        t_result want;
        if (i_rst_n && o_strobe) begin
            n_pixels++;
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel: pixel_index %0d pixel_color %h last_pixel %b",
                       o_result.pixel_index, o_result.pixel_color, o_result.last_pixel);
                n_errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_result.pixel_index !== want.pixel_index) begin
                    $error("pixel_index: expected %0d, actual %0d",
                           want.pixel_index, o_result.pixel_index);
                    n_errors++;
                end
                if (o_result.pixel_color !== want.pixel_color) begin
                    $error("pixel_color: expected %h, actual %h",
                           want.pixel_color, o_result.pixel_color);
                    n_errors++;
                end
                if (o_result.last_pixel !== want.last_pixel) begin
                    $error("last_pixel: expected %b, actual %b",
                           want.last_pixel, o_result.last_pixel);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic void queue_request(input t_request rq, input bit drain);
        t_pending item;
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(0, 15) == 0)
            burst_left = $urandom_range(8, 24);
        item.rq    = rq;
        item.gap   = (burst_left > 0) ? 0 : $urandom_range(0, 15);
        item.drain = drain;
        request_q.push_back(item);
    endfunction

    function automatic t_request random_fields();
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        return noise[$bits(t_request)-1:0];
    endfunction

    // glyphs become drawable once all eight rows have been loaded
    function automatic void queue_load(input logic [7:0] code, input logic [2:0] row,
                                       input logic [7:0] pattern);
        t_request rq;
        int       g;
        rq = random_fields();
        rq.opcode     = OP_LOAD;
        rq.char_code  = code;
        rq.glyph_row  = row;
        rq.glyph_bits = pattern;
        g = int'(code) - int'(FIRST_CODE);
        if (code >= FIRST_CODE && code <= LAST_CODE && g < GLYPH_COUNT_DEF) begin
            if (rows_loaded[g] != 8'hFF) begin
                rows_loaded[g][row] = 1'b1;
                if (rows_loaded[g] == 8'hFF)
                    ready_codes.push_back(int'(code));
            end
        end
        queue_request(rq, 1'b0);
    endfunction

    function automatic void queue_draw(input logic [1:0] op, input logic [7:0] code,
                                       input logic [11:0] x, input logic [11:0] y,
                                       input logic [31:0] fg, input logic [31:0] bg,
                                       input bit drain);
        t_request rq;
        rq = random_fields();
        rq.opcode     = op;
        rq.char_code  = code;
        rq.origin_x   = x;
        rq.origin_y   = y;
        rq.fore_color = fg;
        rq.back_color = bg;
        queue_request(rq, drain);
    endfunction

    // mostly near the visible area so clipping on all four sides gets hit
    function automatic logic [11:0] pick_origin(input int span);
        case ($urandom_range(0, 9))
            0:       return 12'($urandom);
            1:       return 12'(span - 12 + int'($urandom_range(0, 14)));
            2:       return 12'(int'($urandom_range(0, 14)) - 12);
            default: return 12'(int'($urandom_range(0, span + 20)) - 12);
        endcase
    endfunction

    function automatic int random_requests();
        t_request rq;
        int       pick, code;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            code = $urandom_range(FIRST_CODE, LAST_CODE);
            for (int r = 0; r < 8; r++)
                queue_load(8'(code), 3'(r), 8'($urandom));
            return 8;
        end
        if (pick < 14) begin
            queue_load(8'($urandom), 3'($urandom), 8'($urandom));
            return 1;
        end
        rq = random_fields();
        rq.origin_x = pick_origin(eff_dim(width_reg, MAX_WIDTH_DEF));
        rq.origin_y = pick_origin(eff_dim(height_reg, MAX_HEIGHT_DEF));
        if (pick < 24) begin
            rq.opcode    = pick[0] ? OP_OPAQUE : OP_TRANSPARENT;
            rq.char_code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                : 8'($urandom_range(127, 255));
        end else if (pick < 50 || ready_codes.size() == 0) begin
            rq.opcode = OP_CURSOR;
        end else begin
            rq.opcode    = pick[0] ? OP_OPAQUE : OP_TRANSPARENT;
            rq.char_code = 8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
        end
        queue_request(rq, $urandom_range(0, 49) == 0);
        return 1;
    endfunction

    task automatic directed_requests();
        queue_load(8'd31, 3'd0, 8'hFF);
        queue_load(8'd127, 3'd7, 8'hFF);
        for (int r = 0; r < 8; r++)
            queue_load(FIRST_CODE, 3'(r), SPACE_ART[63 - 8*r -: 8]);
        for (int r = 0; r < 8; r++)
            queue_load(LAST_CODE, 3'(r), 8'($urandom));
        queue_draw(OP_OPAQUE, FIRST_CODE, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_draw(OP_TRANSPARENT, LAST_CODE, 12'hFFD, 12'hFFE, 32'h0, 32'hFFFF_FFFF, 1'b0);
        queue_draw(OP_OPAQUE, LAST_CODE, 12'h7FF, 12'h800, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
        queue_draw(OP_OPAQUE, 8'd0, 12'd10, 12'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_draw(OP_TRANSPARENT, 8'd255, 12'd10, 12'd10, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_draw(OP_CURSOR, 8'd65, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0);
        // bottom-right clip, sent only once everything before it has drained
        queue_draw(OP_CURSOR, 8'd65, 12'd795, 12'd595, 32'hFFFF_FFFF, 32'h0, 1'b1);
    endtask

    task automatic settle();
        do
            @(negedge i_clk);
        while (request_q.size() != 0 || start || expected_pixels.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [10:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH)
            width_reg = value;
        else
            height_reg = value;
    endtask

    initial begin : stimulus
        int added;
        foreach (rows_loaded[i]) rows_loaded[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_requests();
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1: begin
                        write_reg(CFG_WIDTH, 11'd1024);
                        write_reg(CFG_HEIGHT, 11'd1024);
                    end
                    2: begin
                        write_reg(CFG_WIDTH, 11'd1);
                        write_reg(CFG_HEIGHT, 11'd1);
                    end
                    3: begin    // both above the cap
                        write_reg(CFG_WIDTH, 11'd2047);
                        write_reg(CFG_HEIGHT, 11'd2047);
                    end
                    4: begin
                        write_reg(CFG_WIDTH, 11'd0);
                        write_reg(CFG_HEIGHT, 11'd600);
                    end
                    5: begin
                        write_reg(CFG_WIDTH, 11'd320);
                        write_reg(CFG_HEIGHT, 11'd0);
                    end
                    default: begin
                        write_reg(CFG_WIDTH, 11'($urandom_range(2, 1100)));
                        write_reg(CFG_HEIGHT, 11'($urandom_range(2, 1100)));
                    end
                endcase
            end
            added = 0;
            while (added < PHASE_ITEMS)
                added += random_requests();
        end
        settle();
        $display("Ran %0d requests (loads, characters, cursors) across %0d screen sizes;",
                 n_requests, PHASES);
        $display("%0d pixel writes compared, %0d mismatches.", n_pixels, n_errors);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
